>>> rtl/fvn_pkg.sv
// Shared types and constants for the float32 value normalizer.
// Holds the command and status structs that join the controller and the datapath.
// No dependencies.
package fvn_pkg;

   localparam int ADDR_W    = 4;
   localparam int DATA_W    = 32;
   localparam int MANT_W    = 24;
   localparam int WIDE_W    = 50;
   localparam int DIV_STEPS = 27;
   localparam int DIV_CNT_W = 5;

   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_SCALE  = 2'd1;
   localparam logic [1:0] REG_THRESH = 2'd2;

   localparam logic [1:0] MODE_RANGE    = 2'd0;
   localparam logic [1:0] MODE_DIVIDE   = 2'd1;
   localparam logic [1:0] MODE_MULTIPLY = 2'd2;

   localparam logic [1:0]  MODE_RESET   = MODE_DIVIDE;
   localparam logic [31:0] SCALE_RESET  = 32'h3F80_0000;
   localparam logic [31:0] THRESH_RESET = 32'h0000_0000;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_CAPTURE,
      CMD_MEASURE,
      CMD_SUB_DIFF,
      CMD_SUB_SHIFT,
      CMD_MUL,
      CMD_DIV_SETUP_F,
      CMD_DIV_SETUP_R,
      CMD_PRENORM,
      CMD_DIV_INIT,
      CMD_DIV_STEP,
      CMD_DIV_END,
      CMD_NORM,
      CMD_DENORM,
      CMD_ROUND,
      CMD_SAVE_DIFF,
      CMD_SAVE_SHIFT,
      CMD_FINISH,
      CMD_ZERO
   } cmd_type;

   typedef struct packed {
      cmd_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic       pass;
      logic [1:0] mode;
      logic       factor_bad;
      logic       x_zero;
      logic       prenorm_done;
      logic       norm_done;
      logic       need_denorm;
      logic       diff_bad;
      logic       shift_bad;
      logic       out_free;
   } dp_status_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] scale;
      logic [31:0] thresh;
   } cfg_type;

   typedef struct packed {
      logic               sign;
      logic signed [9:0]  exp;
      logic [MANT_W-1:0]  mant;
   } unpacked_type;

endpackage

>>> rtl/fvn_csr.sv
// Configuration registers of the float32 value normalizer on an APB-style port.
// Depends on fvn_pkg for register indexes and reset values.
module fvn_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [fvn_pkg::ADDR_W-1:0]  paddr,
   input  logic [fvn_pkg::DATA_W-1:0]  pwdata,
   output logic [fvn_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output fvn_pkg::cfg_type            cfg
);

   logic [1:0]  mode_ff, mode_in;
   logic [31:0] scale_ff, scale_in;
   logic [31:0] thresh_ff, thresh_in;
   logic        wr_en;

   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;

   always_comb begin
      mode_in   = mode_ff;
      scale_in  = scale_ff;
      thresh_in = thresh_ff;
      if (wr_en) begin
         case (paddr[3:2])
            fvn_pkg::REG_MODE:   mode_in   = pwdata[1:0];
            fvn_pkg::REG_SCALE:  scale_in  = pwdata;
            fvn_pkg::REG_THRESH: thresh_in = pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= fvn_pkg::MODE_RESET;
         scale_ff  <= fvn_pkg::SCALE_RESET;
         thresh_ff <= fvn_pkg::THRESH_RESET;
      end else begin
         mode_ff   <= mode_in;
         scale_ff  <= scale_in;
         thresh_ff <= thresh_in;
      end
   end

   always_comb begin
      case (paddr[3:2])
         fvn_pkg::REG_MODE:   prdata = {30'd0, mode_ff};
         fvn_pkg::REG_SCALE:  prdata = scale_ff;
         fvn_pkg::REG_THRESH: prdata = thresh_ff;
         default:             prdata = '0;
      endcase
   end

   assign cfg.mode   = mode_ff;
   assign cfg.scale  = scale_ff;
   assign cfg.thresh = thresh_ff;

endmodule

>>> rtl/fvn_ctrl.sv
// Sequencing state machine of the float32 value normalizer.
// Depends on fvn_pkg for the command and status structs.
module fvn_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fvn_pkg::dp_status_type status,
   output fvn_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [17:0] {
      S_IDLE        = 18'h00001,
      S_DISPATCH    = 18'h00002,
      S_MEASURE     = 18'h00004,
      S_SUB_DIFF    = 18'h00008,
      S_SUB_SHIFT   = 18'h00010,
      S_MUL         = 18'h00020,
      S_DIV_SETUP   = 18'h00040,
      S_PRENORM     = 18'h00080,
      S_DIV_INIT    = 18'h00100,
      S_DIV_STEP    = 18'h00200,
      S_DIV_END     = 18'h00400,
      S_NORM        = 18'h00800,
      S_DENORM      = 18'h01000,
      S_ROUND       = 18'h02000,
      S_SAVE        = 18'h04000,
      S_RANGE_CHECK = 18'h08000,
      S_FINISH      = 18'h10000,
      S_ZERO        = 18'h20000
   } state_type;

   typedef enum logic [1:0] {
      PH_DIFF,
      PH_SHIFT,
      PH_FINAL
   } phase_type;

   state_type                        state_ff, state_in;
   phase_type                        phase_ff, phase_in;
   logic [fvn_pkg::DIV_CNT_W-1:0]    div_cnt_ff, div_cnt_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      div_cnt_in = div_cnt_ff;
      cmd.op     = fvn_pkg::CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = fvn_pkg::CMD_CAPTURE;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            phase_in = PH_FINAL;
            if (!status.pass) begin
               state_in = S_MEASURE;
            end else if (status.mode == fvn_pkg::MODE_RANGE) begin
               phase_in = PH_DIFF;
               state_in = S_SUB_DIFF;
            end else if (status.mode == fvn_pkg::MODE_DIVIDE) begin
               state_in = (status.factor_bad || status.x_zero) ? S_ZERO : S_DIV_SETUP;
            end else begin
               state_in = status.factor_bad ? S_ZERO : S_MUL;
            end
         end
         S_MEASURE: begin
            cmd.op   = fvn_pkg::CMD_MEASURE;
            state_in = S_IDLE;
         end
         S_SUB_DIFF: begin
            cmd.op   = fvn_pkg::CMD_SUB_DIFF;
            state_in = S_NORM;
         end
         S_SUB_SHIFT: begin
            cmd.op   = fvn_pkg::CMD_SUB_SHIFT;
            state_in = S_NORM;
         end
         S_MUL: begin
            cmd.op   = fvn_pkg::CMD_MUL;
            state_in = S_NORM;
         end
         S_DIV_SETUP: begin
            cmd.op   = (status.mode == fvn_pkg::MODE_RANGE) ? fvn_pkg::CMD_DIV_SETUP_R
                                                         : fvn_pkg::CMD_DIV_SETUP_F;
            state_in = S_PRENORM;
         end
         S_PRENORM: begin
            if (status.prenorm_done) begin
               state_in = S_DIV_INIT;
            end else begin
               cmd.op = fvn_pkg::CMD_PRENORM;
            end
         end
         S_DIV_INIT: begin
            cmd.op     = fvn_pkg::CMD_DIV_INIT;
            div_cnt_in = '0;
            state_in   = S_DIV_STEP;
         end
         S_DIV_STEP: begin
            cmd.op = fvn_pkg::CMD_DIV_STEP;
            if (div_cnt_ff == fvn_pkg::DIV_CNT_W'(fvn_pkg::DIV_STEPS - 1)) begin
               state_in = S_DIV_END;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         S_DIV_END: begin
            cmd.op   = fvn_pkg::CMD_DIV_END;
            state_in = S_NORM;
         end
         S_NORM: begin
            if (status.norm_done) begin
               state_in = status.need_denorm ? S_DENORM : S_ROUND;
            end else begin
               cmd.op = fvn_pkg::CMD_NORM;
            end
         end
         S_DENORM: begin
            cmd.op   = fvn_pkg::CMD_DENORM;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            cmd.op   = fvn_pkg::CMD_ROUND;
            state_in = (phase_ff == PH_FINAL) ? S_FINISH : S_SAVE;
         end
         S_SAVE: begin
            if (phase_ff == PH_DIFF) begin
               cmd.op   = fvn_pkg::CMD_SAVE_DIFF;
               phase_in = PH_SHIFT;
               state_in = S_SUB_SHIFT;
            end else begin
               cmd.op   = fvn_pkg::CMD_SAVE_SHIFT;
               phase_in = PH_FINAL;
               state_in = S_RANGE_CHECK;
            end
         end
         S_RANGE_CHECK: begin
            state_in = (status.diff_bad || status.shift_bad) ? S_ZERO : S_DIV_SETUP;
         end
         S_FINISH: begin
            if (status.out_free) begin
               cmd.op   = fvn_pkg::CMD_FINISH;
               state_in = S_IDLE;
            end
         end
         S_ZERO: begin
            if (status.out_free) begin
               cmd.op   = fvn_pkg::CMD_ZERO;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         phase_ff   <= PH_FINAL;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

`ifndef SYNTH
   a_div_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_STEP) |-> (div_cnt_ff < fvn_pkg::DIV_CNT_W'(fvn_pkg::DIV_STEPS)))
      else $error("divider step count ran past its end");
   // A subnormal shift leaves the leading one below the top on purpose.
   a_round_normalized: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND) |-> (status.norm_done || $past(state_ff == S_DENORM)))
      else $error("rounding started on an unnormalized significand");
`endif

endmodule

>>> rtl/fvn_dp.sv
// Datapath of the float32 value normalizer: min/max tracking, subtract, multiply,
// iterative divide, normalize, round and the output register. Depends on fvn_pkg.
module fvn_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  fvn_pkg::ctrl_cmd_type  cmd,
   output fvn_pkg::dp_status_type status,
   input  fvn_pkg::cfg_type       cfg,
   input  logic                   req_pass_select,
   input  logic                   req_first_of_set,
   input  logic [31:0]            req_sample,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [31:0]            rsp_scaled,
   output logic                   rsp_dropped
);

   function automatic logic is_bad(input logic [31:0] b);
      return b[30:23] == 8'hFF;
   endfunction

   function automatic logic is_zero(input logic [31:0] b);
      return b[30:0] == 31'd0;
   endfunction

   function automatic logic is_nan(input logic [31:0] b);
      return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
   endfunction

   function automatic fvn_pkg::unpacked_type unpack(input logic [31:0] b);
      fvn_pkg::unpacked_type u;
      u.sign = b[31];
      if (b[30:23] == 8'd0) begin
         u.exp  = 10'sd1;
         u.mant = {1'b0, b[22:0]};
      end else begin
         u.exp  = {2'b00, b[30:23]};
         u.mant = {1'b1, b[22:0]};
      end
      return u;
   endfunction

   // Ordered less-than on binary32 patterns; any NaN compares false, +0 equals -0.
   function automatic logic flt_lt(input logic [31:0] a, input logic [31:0] b);
      logic r;
      if (is_nan(a) || is_nan(b)) begin
         r = 1'b0;
      end else if (is_zero(a) && is_zero(b)) begin
         r = 1'b0;
      end else if (a[31] != b[31]) begin
         r = a[31];
      end else if (!a[31]) begin
         r = a[30:0] < b[30:0];
      end else begin
         r = a[30:0] > b[30:0];
      end
      return r;
   endfunction

   // Item and tracking registers.
   logic [31:0]              x_ff, x_in;
   logic                     pass_ff, pass_in;
   logic                     first_ff, first_in;
   logic [31:0]              min_ff, min_in;
   logic [31:0]              max_ff, max_in;
   // Working registers.
   fvn_pkg::unpacked_type    opa_ff, opa_in;
   fvn_pkg::unpacked_type    opb_ff, opb_in;
   logic [fvn_pkg::WIDE_W-1:0] m_ff, m_in;
   logic signed [11:0]       e_ff, e_in;
   logic                     s_ff, s_in;
   logic [24:0]              rem_ff, rem_in;
   logic [26:0]              q_ff, q_in;
   logic [31:0]              res_ff, res_in;
   logic [31:0]              diff_ff, diff_in;
   logic [31:0]              shift_ff, shift_in;
   // Output register.
   logic                     out_valid_ff, out_valid_in;
   logic [31:0]              out_scaled_ff, out_scaled_in;
   logic                     out_dropped_ff, out_dropped_in;

   // Subtract unit.
   logic [31:0]              add_a, add_bn, add_big, add_small;
   fvn_pkg::unpacked_type    add_ub, add_us;
   logic signed [9:0]        add_dexp;
   logic [7:0]               add_d;
   logic [26:0]              add_wa, add_wbf, add_wb;
   logic                     add_st;
   logic [27:0]              add_sum;
   logic [fvn_pkg::WIDE_W-1:0] add_m;
   logic signed [11:0]       add_e;
   // Multiply unit.
   fvn_pkg::unpacked_type    mul_ua, mul_ub;
   logic [47:0]              mul_prod;
   logic signed [11:0]       mul_e;
   // Divide step and setup.
   fvn_pkg::unpacked_type    dsu_a, dsu_b;
   logic                     div_ge;
   logic [24:0]              div_r1;
   logic signed [11:0]       div_e;
   // Denormalize and round.
   logic signed [11:0]       den_amt;
   logic                     den_st;
   logic [fvn_pkg::WIDE_W-1:0] den_m;
   logic [23:0]              rnd_top;
   logic                     rnd_inc;
   logic [7:0]               rnd_exp;
   logic [30:0]              rnd_sum;
   logic                     rnd_ovf;
   logic [31:0]              rnd_res;
   // Final checks.
   logic [31:0]              fin_rb;
   logic                     fin_drop;
   logic                     out_free;

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      // Subtract: a - b with |big| >= |small| after the swap.
      add_a     = (cmd.op == fvn_pkg::CMD_SUB_DIFF) ? max_ff : x_ff;
      add_bn    = {~min_ff[31], min_ff[30:0]};
      if (add_a[30:0] < add_bn[30:0]) begin
         add_big   = add_bn;
         add_small = add_a;
      end else begin
         add_big   = add_a;
         add_small = add_bn;
      end
      add_ub   = unpack(add_big);
      add_us   = unpack(add_small);
      add_dexp = add_ub.exp - add_us.exp;
      add_d    = add_dexp[7:0];
      add_wa   = {add_ub.mant, 3'b000};
      add_wbf  = {add_us.mant, 3'b000};
      if (add_d >= 8'd27) begin
         add_wb = {26'd0, |add_us.mant};
      end else begin
         add_st = |(add_wbf & ~({27{1'b1}} << add_d));
         add_wb = (add_wbf >> add_d) | {26'd0, add_st};
      end
      add_st = 1'b0;
      if (add_ub.sign == add_us.sign) begin
         add_sum = {1'b0, add_wa} + {1'b0, add_wb};
      end else begin
         add_sum = {1'b0, add_wa} - {1'b0, add_wb};
      end
      add_m = {add_sum, 22'd0};
      add_e = {{2{add_ub.exp[9]}}, add_ub.exp} + 12'sd1;

      // Multiply.
      mul_ua   = unpack(x_ff);
      mul_ub   = unpack(cfg.scale);
      mul_prod = mul_ua.mant * mul_ub.mant;
      mul_e    = {{2{mul_ua.exp[9]}}, mul_ua.exp} + {{2{mul_ub.exp[9]}}, mul_ub.exp}
                 - 12'sd126;

      // Divide setup operands and one restoring step.
      dsu_a  = (cmd.op == fvn_pkg::CMD_DIV_SETUP_R) ? unpack(shift_ff) : unpack(x_ff);
      dsu_b  = (cmd.op == fvn_pkg::CMD_DIV_SETUP_R) ? unpack(diff_ff) : unpack(cfg.scale);
      div_ge = rem_ff >= {1'b0, opb_ff.mant};
      div_r1 = div_ge ? (rem_ff - {1'b0, opb_ff.mant}) : rem_ff;
      div_e  = {{2{opa_ff.exp[9]}}, opa_ff.exp} - {{2{opb_ff.exp[9]}}, opb_ff.exp} + 12'sd127;

      // Shift right into the subnormal range, keeping a sticky bit.
      den_amt = 12'sd1 - e_ff;
      if (den_amt > 12'sd49) begin
         den_st = |m_ff;
         den_m  = {{(fvn_pkg::WIDE_W-1){1'b0}}, den_st};
      end else begin
         den_st = |(m_ff & ~({fvn_pkg::WIDE_W{1'b1}} << den_amt[5:0]));
         den_m  = (m_ff >> den_amt[5:0]) | {{(fvn_pkg::WIDE_W-1){1'b0}}, den_st};
      end

      // Round to nearest even; the carry runs from the fraction into the exponent.
      rnd_top = m_ff[49:26];
      rnd_inc = m_ff[25] & ((|m_ff[24:0]) | rnd_top[0]);
      rnd_exp = rnd_top[23] ? e_ff[7:0] : 8'd0;
      rnd_sum = {rnd_exp, rnd_top[22:0]} + {30'd0, rnd_inc};
      rnd_ovf = (rnd_top[23] && (e_ff > 12'sd254)) || (rnd_sum[30:23] == 8'hFF);
      rnd_res = rnd_ovf ? {s_ff, 8'hFF, 23'd0} : {s_ff, rnd_sum};

      // Non-finite and below-threshold results become zero.
      fin_rb = is_bad(res_ff) ? 32'd0 : res_ff;
      if (flt_lt(fin_rb, cfg.thresh)) begin
         fin_rb = 32'd0;
      end
      fin_drop = is_zero(fin_rb);
   end

   always_comb begin
      x_in           = x_ff;
      pass_in        = pass_ff;
      first_in       = first_ff;
      min_in         = min_ff;
      max_in         = max_ff;
      opa_in         = opa_ff;
      opb_in         = opb_ff;
      m_in           = m_ff;
      e_in           = e_ff;
      s_in           = s_ff;
      rem_in         = rem_ff;
      q_in           = q_ff;
      res_in         = res_ff;
      diff_in        = diff_ff;
      shift_in       = shift_ff;
      out_valid_in   = out_valid_ff;
      out_scaled_in  = out_scaled_ff;
      out_dropped_in = out_dropped_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      case (cmd.op)
         fvn_pkg::CMD_CAPTURE: begin
            x_in     = is_bad(req_sample) ? 32'd0 : req_sample;
            pass_in  = req_pass_select;
            first_in = req_first_of_set;
         end
         fvn_pkg::CMD_MEASURE: begin
            if (first_ff) begin
               min_in = x_ff;
               max_in = x_ff;
            end else begin
               if (flt_lt(x_ff, min_ff)) begin
                  min_in = x_ff;
               end
               if (flt_lt(max_ff, x_ff)) begin
                  max_in = x_ff;
               end
            end
         end
         fvn_pkg::CMD_SUB_DIFF, fvn_pkg::CMD_SUB_SHIFT: begin
            m_in = add_m;
            e_in = add_e;
            s_in = add_ub.sign;
         end
         fvn_pkg::CMD_MUL: begin
            m_in = {mul_prod, 2'b00};
            e_in = mul_e;
            s_in = mul_ua.sign ^ mul_ub.sign;
         end
         fvn_pkg::CMD_DIV_SETUP_F, fvn_pkg::CMD_DIV_SETUP_R: begin
            opa_in = dsu_a;
            opb_in = dsu_b;
            s_in   = dsu_a.sign ^ dsu_b.sign;
         end
         fvn_pkg::CMD_PRENORM: begin
            if (!opa_ff.mant[23]) begin
               opa_in.mant = {opa_ff.mant[22:0], 1'b0};
               opa_in.exp  = opa_ff.exp - 10'sd1;
            end
            if (!opb_ff.mant[23]) begin
               opb_in.mant = {opb_ff.mant[22:0], 1'b0};
               opb_in.exp  = opb_ff.exp - 10'sd1;
            end
         end
         fvn_pkg::CMD_DIV_INIT: begin
            rem_in = {1'b0, opa_ff.mant};
            q_in   = '0;
            e_in   = div_e;
         end
         fvn_pkg::CMD_DIV_STEP: begin
            rem_in = {div_r1[23:0], 1'b0};
            q_in   = {q_ff[25:0], div_ge};
         end
         fvn_pkg::CMD_DIV_END: begin
            m_in = {q_ff, 22'd0, |rem_ff};
         end
         fvn_pkg::CMD_NORM: begin
            if (m_ff[49:42] == 8'd0) begin
               m_in = {m_ff[41:0], 8'd0};
               e_in = e_ff - 12'sd8;
            end else if (!m_ff[49]) begin
               m_in = {m_ff[48:0], 1'b0};
               e_in = e_ff - 12'sd1;
            end
         end
         fvn_pkg::CMD_DENORM: begin
            m_in = den_m;
            e_in = 12'sd1;
         end
         fvn_pkg::CMD_ROUND: begin
            res_in = rnd_res;
         end
         fvn_pkg::CMD_SAVE_DIFF: begin
            diff_in = res_ff;
         end
         fvn_pkg::CMD_SAVE_SHIFT: begin
            shift_in = res_ff;
         end
         fvn_pkg::CMD_FINISH: begin
            out_valid_in   = 1'b1;
            out_scaled_in  = fin_drop ? 32'd0 : fin_rb;
            out_dropped_in = fin_drop;
         end
         fvn_pkg::CMD_ZERO: begin
            out_valid_in   = 1'b1;
            out_scaled_in  = 32'd0;
            out_dropped_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff       <= 32'd0;
         max_ff       <= 32'd0;
         out_valid_ff <= 1'b0;
      end else begin
         min_ff       <= min_in;
         max_ff       <= max_in;
         out_valid_ff <= out_valid_in;
      end
      x_ff           <= x_in;
      pass_ff        <= pass_in;
      first_ff       <= first_in;
      opa_ff         <= opa_in;
      opb_ff         <= opb_in;
      m_ff           <= m_in;
      e_ff           <= e_in;
      s_ff           <= s_in;
      rem_ff         <= rem_in;
      q_ff           <= q_in;
      res_ff         <= res_in;
      diff_ff        <= diff_in;
      shift_ff       <= shift_in;
      out_scaled_ff  <= out_scaled_in;
      out_dropped_ff <= out_dropped_in;
   end

   assign status.pass         = pass_ff;
   assign status.mode         = cfg.mode;
   assign status.factor_bad   = is_zero(cfg.scale) || is_bad(cfg.scale);
   assign status.x_zero       = is_zero(x_ff);
   assign status.prenorm_done = opa_ff.mant[23] && opb_ff.mant[23];
   assign status.norm_done    = m_ff[49] || (m_ff == '0);
   assign status.need_denorm  = m_ff[49] && (e_ff < 12'sd1);
   assign status.diff_bad     = is_zero(diff_ff) || is_bad(diff_ff);
   assign status.shift_bad    = is_zero(shift_ff) || is_bad(shift_ff);
   assign status.out_free     = out_free;

   assign rsp_valid   = out_valid_ff;
   assign rsp_scaled  = out_scaled_ff;
   assign rsp_dropped = out_dropped_ff;

`ifndef SYNTH
   a_drop_is_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_dropped_ff) |-> (out_scaled_ff == 32'd0))
      else $error("dropped result carries a nonzero value");
   a_result_finite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_scaled_ff[30:23] != 8'hFF))
      else $error("non-finite result delivered");
   a_min_not_above_max: assert property (@(posedge clock) disable iff (reset)
      !flt_lt(max_ff, min_ff))
      else $error("running minimum exceeds running maximum");
`endif

endmodule

>>> rtl/float32_value_normalizer_unit.sv
// One beat at a time: the next beat can be taken in the cycle after the result loads. The
// 27-step divider, subnormal pre-shifts and the normalize loop, which shifts by eight bit
// positions or by one per step, set the length of a beat; a held result stalls the sequencer.
// Reset: synchronous, active high; resets the sequencer, min/max, result valid and CSRs.
//
// Top level of the float32 value normalizer. Depends on fvn_pkg, fvn_csr, fvn_ctrl, fvn_dp.
module float32_value_normalizer_unit (
   input  logic                        clock,
   input  logic                        reset,
   // Input beats.
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_pass_select,
   input  logic                        req_first_of_set,
   input  logic [31:0]                 req_sample,
   // Result beats.
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [31:0]                 rsp_scaled,
   output logic                        rsp_dropped,
   // Configuration port.
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [fvn_pkg::ADDR_W-1:0]  paddr,
   input  logic [fvn_pkg::DATA_W-1:0]  pwdata,
   output logic [fvn_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);

   // The controller steps each beat through the datapath one operation at a time. A transform
   // beat in range mode runs two subtractions and then the divide; the other modes run a single
   // divide or multiply. Every arithmetic result passes through the same normalize, optional
   // subnormal shift and round-to-nearest-even sequence.

   fvn_pkg::cfg_type       cfg;
   fvn_pkg::ctrl_cmd_type  cmd;
   fvn_pkg::dp_status_type status;

   fvn_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencer; it takes a new beat only while idle.
   fvn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic, running min/max and the result register.
   fvn_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .cfg              (cfg),
      .req_pass_select  (req_pass_select),
      .req_first_of_set (req_first_of_set),
      .req_sample       (req_sample),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_scaled       (rsp_scaled),
      .rsp_dropped      (rsp_dropped)
   );

endmodule
